>>> rtl/assert_macros.svh
// Assertion macros for the motor run state supervisor RTL.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/mrss_pkg.sv
// Package for the motor run state supervisor: payload types, register
// indexes and configuration reset values. No dependencies.
`timescale 1ns / 1ps

package mrss_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_SPEED_LIMIT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_SETTLE_UPDATES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTACTOR_CHECK    = 2'd2;

    localparam logic [15:0] ZERO_SPEED_LIMIT_RST   = 16'd500;
    localparam logic [7:0]  PWM_SETTLE_UPDATES_RST = 8'd2;
    localparam logic        CONTACTOR_CHECK_RST    = 1'b1;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PWM  = 1'b1;

    localparam logic [7:0] SETTLE_MAX = 8'hFF;

    // Input payload, lowest field last.
    typedef struct packed {
        logic signed [15:0] mech_speed_rpm;
        logic [7:0]         hall_fault_code;
        logic               stall_detected;
        logic               contactor_closed;
        logic               bus_under_volt;
        logic               phase_over_current;
        logic               bus_over_volt;
        logic               run_clear;
        logic               run_set;
    } in_item_t;

    // Result payload, lowest field last.
    typedef struct packed {
        logic       target_zero;
        logic       clear_stall;
        logic       force_control_step;
        logic       clear_loops;
        logic       run_flag;
        logic       pwm_enable;
        logic [2:0] motor_state;
    } out_item_t;

endpackage

>>> rtl/motor_run_state_supervisor_unit.sv
// Motor run state supervisor: five-state drive supervisor with config port.
// Depends on mrss_pkg and assert_macros.svh.
// Each result is registered in the output buffer. Throughput: one request per
// cycle while the skid slot is empty; the state update is a single pass of
// next-state logic, and a two-entry output buffer keeps accepting while one
// result waits. Reset (rst_n low, asynchronous) returns to idle with
// configuration registers at their defaults and the output buffer empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module motor_run_state_supervisor_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mrss_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mrss_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // s_tdata, from bit 0: run_set, run_clear, bus_over_volt, phase_over_current,
    // bus_under_volt, contactor_closed, stall_detected, hall_fault_code[7:0],
    // mech_speed_rpm[15:0], one unused pad bit.
    input  logic [mrss_pkg::IN_DATA_W-1:0]       s_tdata,
    // s_tuser: opcode (0 tick, 1 PWM update).
    input  logic                                 s_tuser,
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // m_tdata, from bit 0: motor_state[2:0], pwm_enable, run_flag, clear_loops,
    // force_control_step, clear_stall, target_zero, seven zero pad bits.
    output logic [mrss_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import mrss_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_INIT = 3'd1,
        ST_RUN  = 3'd2,
        ST_STOP = 3'd3,
        ST_WAIT = 3'd4
    } state_t;

    localparam int OUT_PAD_W = OUT_DATA_W - $bits(out_item_t);

    // Configuration registers.
    logic [15:0] zero_speed_limit_reg;
    logic [7:0]  pwm_settle_updates_reg;
    logic        contactor_check_reg;

    // Supervisor state.
    state_t      state_reg, state_next;
    logic        run_request_reg, run_request_next;
    logic        pwm_on_reg, pwm_on_next;
    logic [15:0] zero_count_reg, zero_count_next;
    logic [7:0]  settle_count_reg, settle_count_next;
    logic        init_entered_reg, init_entered_next;

    // Output buffer: main slot plus skid slot.
    out_item_t   out_item_reg, skid_item_reg;
    logic        out_valid_reg, skid_valid_reg;

    in_item_t    in_item;
    out_item_t   result;
    logic        s_accept, m_pop, tick;
    logic        run_req_cmd, any_fault, speed_zero;
    logic        p_clear, p_force, p_stall, p_target;
    logic [15:0] zero_count_inc;
    logic [7:0]  settle_sat;

    assign in_item    = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
    assign cfg_ready  = 1'b1;
    assign s_tready   = !skid_valid_reg;
    assign s_accept   = s_tvalid && s_tready;
    assign m_tvalid   = out_valid_reg;
    assign m_pop      = out_valid_reg && m_tready;
    assign m_tdata    = {{OUT_PAD_W{1'b0}}, out_item_reg};
    assign tick       = (s_tuser == OP_TICK);
    assign speed_zero = (in_item.mech_speed_rpm == 16'sd0);
    assign any_fault  = in_item.bus_over_volt || in_item.phase_over_current
                     || in_item.bus_under_volt || in_item.stall_detected
                     || (in_item.hall_fault_code != 8'd0);
    assign zero_count_inc = zero_count_reg + 16'd1;
    assign settle_sat = (settle_count_reg < SETTLE_MAX) ? settle_count_reg + 8'd1
                                                        : settle_count_reg;

    // The run bits apply first, on every item whatever its kind.
    always_comb
    begin
        priority if (in_item.run_clear)
            run_req_cmd = 1'b0;
        else if (in_item.run_set)
            run_req_cmd = 1'b1;
        else
            run_req_cmd = run_request_reg;
    end

    always_comb
    begin
        state_next        = state_reg;
        run_request_next  = run_req_cmd;
        pwm_on_next       = pwm_on_reg;
        zero_count_next   = zero_count_reg;
        settle_count_next = settle_count_reg;
        init_entered_next = init_entered_reg;
        p_clear  = 1'b0;
        p_force  = 1'b0;
        p_stall  = 1'b0;
        p_target = 1'b0;
        if (tick)
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (run_req_cmd && !in_item.bus_over_volt
                        && !in_item.phase_over_current && !in_item.bus_under_volt
                        && (!contactor_check_reg || in_item.contactor_closed))
                    begin
                        state_next        = ST_INIT;
                        init_entered_next = 1'b0;
                    end
                end
                ST_INIT:
                begin
                    if (!init_entered_reg)
                    begin
                        p_clear           = 1'b1;
                        p_force           = 1'b1;
                        pwm_on_next       = 1'b1;
                        settle_count_next = 8'd0;
                        init_entered_next = 1'b1;
                    end
                end
                ST_RUN:
                begin
                    if (!run_req_cmd || any_fault)
                    begin
                        pwm_on_next = 1'b0;
                        state_next  = ST_STOP;
                    end
                end
                ST_STOP:
                begin
                    p_target         = 1'b1;
                    run_request_next = 1'b0;
                    if (speed_zero)
                    begin
                        // Counts zero-speed ticks; cleared on leaving to ST_WAIT.
                        if (zero_count_inc > zero_speed_limit_reg)
                        begin
                            zero_count_next = 16'd0;
                            state_next      = ST_WAIT;
                        end
                        else
                            zero_count_next = zero_count_inc;
                    end
                end
                ST_WAIT:
                begin
                    p_target    = 1'b1;
                    p_clear     = 1'b1;
                    p_stall     = 1'b1;
                    pwm_on_next = 1'b0;
                    state_next  = ST_IDLE;
                end
                default:
                    state_next = ST_STOP;
            endcase
        end
        else if (state_reg == ST_INIT && init_entered_reg)
        begin
            settle_count_next = settle_sat;
            if (settle_sat >= pwm_settle_updates_reg)
            begin
                state_next        = ST_RUN;
                init_entered_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        result.motor_state        = state_next;
        result.pwm_enable         = pwm_on_next;
        result.run_flag           = run_request_next;
        result.clear_loops        = p_clear;
        result.force_control_step = p_force;
        result.clear_stall        = p_stall;
        result.target_zero        = p_target;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_speed_limit_reg   <= ZERO_SPEED_LIMIT_RST;
            pwm_settle_updates_reg <= PWM_SETTLE_UPDATES_RST;
            contactor_check_reg    <= CONTACTOR_CHECK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ZERO_SPEED_LIMIT:   zero_speed_limit_reg   <= cfg_data;
                CFG_PWM_SETTLE_UPDATES: pwm_settle_updates_reg <= cfg_data[7:0];
                CFG_CONTACTOR_CHECK:    contactor_check_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            run_request_reg  <= 1'b0;
            pwm_on_reg       <= 1'b0;
            zero_count_reg   <= 16'd0;
            settle_count_reg <= 8'd0;
            init_entered_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            state_reg        <= state_next;
            run_request_reg  <= run_request_next;
            pwm_on_reg       <= pwm_on_next;
            zero_count_reg   <= zero_count_next;
            settle_count_reg <= settle_count_next;
            init_entered_reg <= init_entered_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_item_reg   <= '0;
            skid_item_reg  <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_pop)
        begin
            if (skid_valid_reg)
            begin
                out_item_reg   <= skid_item_reg;
                skid_valid_reg <= 1'b0;
            end
            else if (s_accept)
                out_item_reg <= result;
            else
                out_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            if (!out_valid_reg)
            begin
                out_item_reg  <= result;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_item_reg  <= result;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg)
    `ASSERT_ALWAYS(a_idle_pwm_off, state_reg != ST_IDLE || !pwm_on_reg)
    `ASSERT_ALWAYS(a_entered_only_in_init, !init_entered_reg || state_reg == ST_INIT)
    `ASSERT_NEXT(a_wait_to_idle, s_accept && tick && state_reg == ST_WAIT, state_reg == ST_IDLE)

endmodule
